FILE: rtl/core/spe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spe_pkg
// Shared types and constants of the SPI EEPROM page engine.
// ----------------------------------------------------------------------------
package spe_pkg;

	localparam int PAGE_BYTES = 64;
	localparam int PAGE_COUNT = 512;

	localparam int IDX_W  = $clog2(PAGE_BYTES);
	localparam int PAGE_W = $clog2(PAGE_COUNT);
	// a data frame is opcode, two address bytes and the page
	localparam int FRAME_DATA_LEN = PAGE_BYTES + 3;
	localparam int CNT_W          = $clog2(FRAME_DATA_LEN + 1);

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [7:0] CMD_WREN  = 8'h06;
	localparam logic [7:0] CMD_WRDI  = 8'h05;
	localparam logic [7:0] CMD_WRITE = 8'h02;
	localparam logic [7:0] CMD_READ  = 8'h03;
	localparam logic [7:0] CMD_FILL  = 8'h00;

	localparam logic [7:0] HALF_BIT_RESET = 8'd5;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_WREN,
		PH_WDATA,
		PH_WRDI,
		PH_READ
	} phase_t;

	typedef enum logic {
		CTL_RUN,
		CTL_LOAD
	} ctl_state_t;

	typedef struct packed {
		logic [1:0] op;
		logic [8:0] page;
		logic [5:0] byte_index;
		logic [7:0] data_byte;
		logic       raw;
		logic       miso;
	} item_t;

	typedef struct packed {
		logic       cs_n;
		logic       sck;
		logic       mosi;
		logic       wp;
		logic       busy_res;
		logic       rd_valid;
		logic [5:0] rd_index;
		logic [7:0] rd_byte;
		logic       done_res;
		logic       sum_match;
	} result_t;

	typedef struct packed {
		logic cs_n;
		logic sck;
		logic mosi;
		logic wp;
	} pins_t;

	// per-item events of the serial engine
	typedef struct packed {
		logic       rd_valid;
		logic [5:0] rd_index;
		logic [7:0] rd_byte;
		logic       done;
		logic       ok;
	} spe_ev_t;

	typedef struct packed {
		logic [IDX_W-1:0] rd_addr;
		logic             ld_en;
		logic [IDX_W-1:0] ld_index;
		logic [7:0]       ld_data;
		logic             ck_en;
	} store_req_t;

endpackage

FILE: rtl/core/spi_eeprom_page_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_eeprom_page_engine_top
// SPI master moving 64-byte EEPROM pages: page store, frame engine, result reg.
// ----------------------------------------------------------------------------
// result: registered, shown in the cycle after the item's transfer;
//   a page byte load also passes the load state (old byte read from the store)
// throughput: one item per cycle unless the held result stalls; a load stalls
//   the next item in its load state, due to the page store's single read port
// reset: asynchronous, active low; pins high, engine idle, page store reads zero
// ----------------------------------------------------------------------------
module spi_eeprom_page_engine_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_data,
	input  logic             item_valid,
	output logic             item_stall,
	input  spe_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output spe_pkg::result_t result
);

	spe_pkg::ctl_state_t       ctl_q, ctl_n;
	logic [7:0]                half_bit_q;
	logic [spe_pkg::IDX_W-1:0] ld_index_q;
	logic [7:0]                ld_data_q;
	logic                      res_valid_q;
	spe_pkg::spe_ev_t          ev_q;

	logic                      item_take;
	logic                      is_load;
	logic                      eng_step;
	logic                      produce;
	spe_pkg::spe_ev_t          eng_ev;
	spe_pkg::pins_t            eng_pins;
	logic                      eng_busy;
	logic                      eng_ck;
	logic [spe_pkg::IDX_W-1:0] eng_pf_addr;
	logic [7:0]                store_rdata;
	spe_pkg::store_req_t       store_req;

	assign cfg_ready  = 1'b1;
	assign item_stall = (ctl_q == spe_pkg::CTL_LOAD) || (res_valid_q && result_stall);
	assign item_take  = item_valid && !item_stall;
	assign is_load    = item_take && !eng_busy && (item.op == spe_pkg::OP_LOAD);
	assign eng_step   = item_take && !is_load;
	assign produce    = eng_step || (ctl_q == spe_pkg::CTL_LOAD);

	always_comb begin
		store_req.rd_addr  = is_load ? spe_pkg::IDX_W'(item.byte_index) : eng_pf_addr;
		store_req.ld_en    = (ctl_q == spe_pkg::CTL_LOAD);
		store_req.ld_index = ld_index_q;
		store_req.ld_data  = ld_data_q;
		store_req.ck_en    = eng_ck;
	end

	spe_page_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (store_req),
		.rd_data (store_rdata)
	);

	spe_serial_engine u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (eng_step),
		.item           (item),
		.half_bit_ticks (half_bit_q),
		.store_rdata    (store_rdata),
		.ev             (eng_ev),
		.pins           (eng_pins),
		.busy           (eng_busy),
		.ck_en          (eng_ck),
		.pf_addr        (eng_pf_addr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= spe_pkg::CTL_RUN;
		end else begin
			ctl_q <= ctl_n;
		end
	end

	always_comb begin
		ctl_n = ctl_q;
		unique case (ctl_q)
			spe_pkg::CTL_RUN: begin
				if (is_load) begin
					ctl_n = spe_pkg::CTL_LOAD;
				end
			end
			spe_pkg::CTL_LOAD: ctl_n = spe_pkg::CTL_RUN;
			default:           ctl_n = spe_pkg::CTL_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_bit_q  <= spe_pkg::HALF_BIT_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				half_bit_q <= cfg_data;
			end
			if (produce) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_load) begin
			ld_index_q <= spe_pkg::IDX_W'(item.byte_index);
			ld_data_q  <= item.data_byte;
		end
		if (produce) begin
			ev_q <= eng_step ? eng_ev : '0;
		end
	end

	// pins and busy only move on a transfer, so they stay with the held result
	assign result_valid       = res_valid_q;
	assign result.cs_n        = eng_pins.cs_n;
	assign result.sck         = eng_pins.sck;
	assign result.mosi        = eng_pins.mosi;
	assign result.wp          = eng_pins.wp;
	assign result.busy_res    = eng_busy;
	assign result.rd_valid    = ev_q.rd_valid;
	assign result.rd_index    = ev_q.rd_index;
	assign result.rd_byte     = ev_q.rd_byte;
	assign result.done_res    = ev_q.done;
	assign result.sum_match   = ev_q.ok;

endmodule

FILE: rtl/core/spe_page_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spe_page_store
// Page buffer memory with per-entry valid bits and the running byte sum.
// ----------------------------------------------------------------------------
module spe_page_store (
	input  logic                     clk,
	input  logic                     arst_n,
	input  spe_pkg::store_req_t      req,
	output logic [7:0]               rd_data
);

	logic [7:0]                    mem [spe_pkg::PAGE_BYTES];
	logic [spe_pkg::PAGE_BYTES-1:0] vld_q;
	logic [7:0]                    sum_q;
	logic [7:0]                    rraw_q;
	logic                          rvld_q;

	// entries never written read as zero
	assign rd_data = rvld_q ? rraw_q : 8'h00;

	always_ff @(posedge clk) begin
		if (req.ld_en) begin
			mem[req.ld_index] <= req.ld_data;
		end else if (req.ck_en) begin
			mem[0] <= ~sum_q;
		end
		rraw_q <= mem[req.rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			sum_q  <= 8'h00;
			rvld_q <= 1'b0;
		end else begin
			rvld_q <= vld_q[req.rd_addr];
			if (req.ld_en) begin
				vld_q[req.ld_index] <= 1'b1;
				// rd_data holds the old byte, fetched when the load was taken
				if (req.ld_index != '0) begin
					sum_q <= sum_q - rd_data + req.ld_data;
				end
			end else if (req.ck_en) begin
				vld_q[0] <= 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/spe_serial_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spe_serial_engine
// Frame sequencer, clock divider and bit-serial shifters of the SPI master.
// ----------------------------------------------------------------------------
module spe_serial_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  spe_pkg::item_t             item,
	input  logic [7:0]                 half_bit_ticks,
	input  logic [7:0]                 store_rdata,
	output spe_pkg::spe_ev_t           ev,
	output spe_pkg::pins_t             pins,
	output logic                       busy,
	output logic                       ck_en,
	output logic [spe_pkg::IDX_W-1:0]  pf_addr
);

	spe_pkg::phase_t              phase_q, phase_n;
	logic [spe_pkg::CNT_W-1:0]    byte_cnt_q, byte_cnt_n;
	logic [2:0]                   bit_cnt_q, bit_cnt_n;
	logic [7:0]                   tick_q, tick_n;
	logic [7:0]                   tx_q, tx_n;
	logic [7:0]                   rx_q, rx_n;
	logic [spe_pkg::PAGE_W-1:0]   page_q, page_n;
	logic [7:0]                   rsum_q, rsum_n;
	logic [7:0]                   rchk_q, rchk_n;
	spe_pkg::pins_t               pins_q, pins_n;

	logic [15:0]                  addr;
	logic [spe_pkg::CNT_W-1:0]    cnt_inc;
	logic [spe_pkg::CNT_W-1:0]    data_idx;
	logic [8:0]                   tick_inc;
	logic [7:0]                   tx_shl;
	logic [7:0]                   first_byte;
	logic [7:0]                   next_byte;
	logic                         data_frame;
	spe_pkg::phase_t              start_phase;

	assign pins    = pins_q;
	assign busy    = (phase_q != spe_pkg::PH_IDLE);
	// store byte needed at the next byte boundary
	assign pf_addr = spe_pkg::IDX_W'(byte_cnt_q - spe_pkg::CNT_W'(2));
	assign addr    = 16'(32'(page_q) * spe_pkg::PAGE_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= spe_pkg::PH_IDLE;
			byte_cnt_q <= '0;
			bit_cnt_q  <= '0;
			tick_q     <= '0;
			tx_q       <= '0;
			rx_q       <= '0;
			page_q     <= '0;
			rsum_q     <= '0;
			rchk_q     <= '0;
			pins_q     <= '{cs_n: 1'b1, sck: 1'b1, mosi: 1'b1, wp: 1'b1};
		end else begin
			phase_q    <= phase_n;
			byte_cnt_q <= byte_cnt_n;
			bit_cnt_q  <= bit_cnt_n;
			tick_q     <= tick_n;
			tx_q       <= tx_n;
			rx_q       <= rx_n;
			page_q     <= page_n;
			rsum_q     <= rsum_n;
			rchk_q     <= rchk_n;
			pins_q     <= pins_n;
		end
	end

	always_comb begin
		phase_n    = phase_q;
		byte_cnt_n = byte_cnt_q;
		bit_cnt_n  = bit_cnt_q;
		tick_n     = tick_q;
		tx_n       = tx_q;
		rx_n       = rx_q;
		page_n     = page_q;
		rsum_n     = rsum_q;
		rchk_n     = rchk_q;
		pins_n     = pins_q;
		ev         = '0;
		ck_en      = 1'b0;

		cnt_inc    = byte_cnt_q + spe_pkg::CNT_W'(1);
		data_idx   = byte_cnt_q - spe_pkg::CNT_W'(3);
		tick_inc   = {1'b0, tick_q} + 9'd1;
		tx_shl     = {tx_q[6:0], 1'b0};
		data_frame = (phase_q == spe_pkg::PH_WDATA) || (phase_q == spe_pkg::PH_READ);

		start_phase = (item.op == spe_pkg::OP_WRITE) ? spe_pkg::PH_WREN : spe_pkg::PH_READ;

		// opening byte of a frame of the phase about to run
		unique case (busy ? phase_q : start_phase)
			spe_pkg::PH_WREN:  first_byte = spe_pkg::CMD_WREN;
			spe_pkg::PH_WRDI:  first_byte = spe_pkg::CMD_WRDI;
			spe_pkg::PH_WDATA: first_byte = spe_pkg::CMD_WRITE;
			spe_pkg::PH_READ:  first_byte = spe_pkg::CMD_READ;
			default:           first_byte = spe_pkg::CMD_FILL;
		endcase

		// byte that follows the one just finished
		if (cnt_inc == spe_pkg::CNT_W'(1)) begin
			next_byte = addr[15:8];
		end else if (cnt_inc == spe_pkg::CNT_W'(2)) begin
			next_byte = addr[7:0];
		end else if (phase_q == spe_pkg::PH_READ) begin
			next_byte = spe_pkg::CMD_FILL;
		end else begin
			next_byte = store_rdata;
		end

		if (step) begin
			if (!busy) begin
				if (item.op == spe_pkg::OP_WRITE || item.op == spe_pkg::OP_READ) begin
					page_n  = spe_pkg::PAGE_W'(item.page);
					phase_n = start_phase;
					if (item.op == spe_pkg::OP_WRITE) begin
						pins_n.wp = 1'b1;
						ck_en     = !item.raw;
					end else begin
						rsum_n = '0;
						rchk_n = '0;
					end
					byte_cnt_n  = '0;
					bit_cnt_n   = '0;
					tick_n      = '0;
					tx_n        = first_byte;
					pins_n.cs_n = 1'b0;
					pins_n.sck  = 1'b0;
					pins_n.mosi = first_byte[7];
				end
			end else if (item.op == spe_pkg::OP_TICK) begin
				if (pins_q.cs_n) begin
					// gap between frames: open the next one
					byte_cnt_n  = '0;
					bit_cnt_n   = '0;
					tick_n      = '0;
					tx_n        = first_byte;
					pins_n.cs_n = 1'b0;
					pins_n.sck  = 1'b0;
					pins_n.mosi = first_byte[7];
				end else if (tick_inc < {1'b0, half_bit_ticks}) begin
					tick_n = tick_inc[7:0];
				end else begin
					tick_n = '0;
					if (!pins_q.sck) begin
						pins_n.sck = 1'b1;
						rx_n       = {rx_q[6:0], item.miso};
					end else begin
						tx_n = tx_shl;
						if (bit_cnt_q != 3'd7) begin
							bit_cnt_n   = bit_cnt_q + 3'd1;
							pins_n.mosi = tx_shl[7];
							pins_n.sck  = 1'b0;
						end else begin
							bit_cnt_n = '0;
							if (phase_q == spe_pkg::PH_READ &&
							    byte_cnt_q >= spe_pkg::CNT_W'(3)) begin
								ev.rd_valid = 1'b1;
								ev.rd_index = 6'(data_idx);
								ev.rd_byte  = rx_q;
								if (data_idx == '0) begin
									rchk_n = rx_q;
								end else begin
									rsum_n = rsum_q + rx_q;
								end
							end
							byte_cnt_n = cnt_inc;
							if (data_frame &&
							    cnt_inc < spe_pkg::CNT_W'(spe_pkg::FRAME_DATA_LEN)) begin
								tx_n        = next_byte;
								pins_n.mosi = next_byte[7];
								pins_n.sck  = 1'b0;
							end else begin
								pins_n.cs_n = 1'b1;
								unique case (phase_q)
									spe_pkg::PH_WREN:  phase_n = spe_pkg::PH_WDATA;
									spe_pkg::PH_WDATA: phase_n = spe_pkg::PH_WRDI;
									spe_pkg::PH_WRDI: begin
										pins_n.wp = 1'b0;
										phase_n   = spe_pkg::PH_IDLE;
										ev.done   = 1'b1;
									end
									spe_pkg::PH_READ: begin
										phase_n = spe_pkg::PH_IDLE;
										ev.done = 1'b1;
										ev.ok   = (rchk_n == ~rsum_n);
									end
									default: phase_n = spe_pkg::PH_IDLE;
								endcase
							end
						end
					end
				end
			end
		end
	end

endmodule

FILE: rtl/core/spe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spe_checker
// Port-level checks of the SPI EEPROM page engine, bound to the top level.
// ----------------------------------------------------------------------------
module spe_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_stall,
	input spe_pkg::result_t result
);

	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// a finished transaction leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.done_res |-> !result.busy_res)
		else $error("done reported while still busy");

	a_ok_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.sum_match |-> result.done_res)
		else $error("checksum flag without done");

	// between transactions chip select and the serial clock rest high
	a_idle_pins: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.busy_res |-> result.cs_n && result.sck)
		else $error("bus not parked while idle");

endmodule

bind spi_eeprom_page_engine_top spe_checker u_spe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SPI EEPROM page engine. A cycle model of the
// page store and serial engine predicts every result at its transfer; results
// are compared field by field in order while both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

	// covers the long receiver hold and the sender gaps
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PRINT_LIMIT    = 50;

	typedef enum {
		STALL_NONE,
		STALL_LIGHT,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [7:0]        cfg_data;
	logic              item_valid;
	logic              item_stall;
	spe_pkg::item_t    item;
	logic              result_valid;
	logic              result_stall;
	spe_pkg::result_t  result;

	spi_eeprom_page_engine_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// mirror of the page store and serial engine
	logic [7:0]       half_bit;
	logic [7:0]       img_store [spe_pkg::PAGE_BYTES];
	logic [7:0]       img_sum;
	spe_pkg::phase_t  eng_phase;
	int unsigned      eng_bytes;
	int unsigned      eng_bits;
	logic [7:0]       eng_tx;
	logic [7:0]       eng_rx;
	logic [7:0]       eng_tick;
	logic [8:0]       eng_page;
	logic             eng_raw;
	logic [7:0]       rd_sum;
	logic [7:0]       rd_check;
	spe_pkg::pins_t   eng_pins;

	// contents the eeprom drives back during a read
	logic [7:0] eeprom_image [spe_pkg::PAGE_BYTES];
	bit         image_on = 1'b0;

	spe_pkg::result_t line_state_q[$];
	int      err_count   = 0;
	int      burst_left  = 0;
	bit      offering    = 1'b0;
	int      long_hold   = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void engine_reset();
		half_bit = spe_pkg::HALF_BIT_RESET;
		foreach (img_store[i])
			img_store[i] = 8'h00;
		img_sum   = 8'h00;
		eng_phase = spe_pkg::PH_IDLE;
		eng_bytes = 0;
		eng_bits  = 0;
		eng_tx    = 8'h00;
		eng_rx    = 8'h00;
		eng_tick  = 8'h00;
		eng_page  = '0;
		eng_raw   = 1'b0;
		rd_sum    = 8'h00;
		rd_check  = 8'h00;
		eng_pins  = '1;
	endfunction

	function automatic int unsigned frame_len();
		return (eng_phase == spe_pkg::PH_WREN || eng_phase == spe_pkg::PH_WRDI) ?
			1 : spe_pkg::FRAME_DATA_LEN;
	endfunction

	function automatic logic [7:0] frame_byte(int unsigned idx);
		logic [15:0] addr;
		addr = 16'(eng_page * spe_pkg::PAGE_BYTES);
		if (eng_phase == spe_pkg::PH_WREN)
			return spe_pkg::CMD_WREN;
		if (eng_phase == spe_pkg::PH_WRDI)
			return spe_pkg::CMD_WRDI;
		if (idx == 0)
			return (eng_phase == spe_pkg::PH_READ) ? spe_pkg::CMD_READ : spe_pkg::CMD_WRITE;
		if (idx == 1)
			return addr[15:8];
		if (idx == 2)
			return addr[7:0];
		if (eng_phase == spe_pkg::PH_READ)
			return spe_pkg::CMD_FILL;
		return img_store[idx - 3];
	endfunction

	function automatic void open_frame();
		eng_bytes     = 0;
		eng_bits      = 0;
		eng_tick      = 8'h00;
		eng_tx        = frame_byte(0);
		eng_pins.cs_n = 1'b0;
		eng_pins.sck  = 1'b0;
		eng_pins.mosi = eng_tx[7];
	endfunction

	// advances the mirror by one item and returns the line levels and events
	function automatic spe_pkg::result_t spi_master_step(spe_pkg::item_t it);
		spe_pkg::result_t r;
		int unsigned      h;
		r = '0;
		h = (half_bit == 8'd0) ? 1 : half_bit;
		if (eng_phase == spe_pkg::PH_IDLE) begin
			if (it.op == spe_pkg::OP_LOAD) begin
				// byte 0 is the checksum slot and stays out of the sum
				if (it.byte_index != 0)
					img_sum = img_sum - img_store[it.byte_index] + it.data_byte;
				img_store[it.byte_index] = it.data_byte;
			end else if (it.op == spe_pkg::OP_WRITE || it.op == spe_pkg::OP_READ) begin
				eng_page = it.page;
				if (it.op == spe_pkg::OP_WRITE) begin
					eng_raw = it.raw;
					if (!eng_raw)
						img_store[0] = ~img_sum;
					eng_phase   = spe_pkg::PH_WREN;
					eng_pins.wp = 1'b1;
				end else begin
					rd_sum    = 8'h00;
					rd_check  = 8'h00;
					eng_phase = spe_pkg::PH_READ;
				end
				open_frame();
			end
		end else if (it.op == spe_pkg::OP_TICK) begin
			if (eng_pins.cs_n) begin
				open_frame();
			end else if (eng_tick + 1 < h) begin
				eng_tick++;
			end else begin
				eng_tick = 8'h00;
				if (!eng_pins.sck) begin
					eng_pins.sck = 1'b1;
					eng_rx       = {eng_rx[6:0], it.miso};
				end else begin
					eng_bits++;
					eng_tx = eng_tx << 1;
					if (eng_bits < 8) begin
						eng_pins.mosi = eng_tx[7];
						eng_pins.sck  = 1'b0;
					end else begin
						eng_bits = 0;
						if (eng_phase == spe_pkg::PH_READ && eng_bytes >= 3) begin
							r.rd_valid = 1'b1;
							r.rd_index = 6'(eng_bytes - 3);
							r.rd_byte  = eng_rx;
							if (eng_bytes == 3)
								rd_check = eng_rx;
							else
								rd_sum = rd_sum + eng_rx;
						end
						eng_bytes++;
						if (eng_bytes < frame_len()) begin
							eng_tx        = frame_byte(eng_bytes);
							eng_pins.mosi = eng_tx[7];
							eng_pins.sck  = 1'b0;
						end else begin
							eng_pins.cs_n = 1'b1;
							case (eng_phase)
								spe_pkg::PH_WREN: eng_phase = spe_pkg::PH_WDATA;
								spe_pkg::PH_WDATA: eng_phase = spe_pkg::PH_WRDI;
								spe_pkg::PH_WRDI: begin
									eng_pins.wp = 1'b0;
									eng_phase   = spe_pkg::PH_IDLE;
									r.done_res  = 1'b1;
								end
								default: begin
									eng_phase   = spe_pkg::PH_IDLE;
									r.done_res  = 1'b1;
									r.sum_match = (rd_check == ~rd_sum);
								end
							endcase
						end
					end
				end
			end
		end
		r.cs_n     = eng_pins.cs_n;
		r.sck      = eng_pins.sck;
		r.mosi     = eng_pins.mosi;
		r.wp       = eng_pins.wp;
		r.busy_res = (eng_phase != spe_pkg::PH_IDLE);
		return r;
	endfunction

	// miso follows the eeprom image on read data bytes, random elsewhere
	function automatic logic planned_miso();
		if (image_on && eng_phase == spe_pkg::PH_READ && eng_bytes >= 3)
			return eeprom_image[eng_bytes - 3][7 - eng_bits];
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic spe_pkg::item_t noise_item(logic [1:0] op);
		spe_pkg::item_t it;
		it.op         = op;
		it.page       = 9'($urandom_range(0, spe_pkg::PAGE_COUNT - 1));
		it.byte_index = 6'($urandom_range(0, spe_pkg::PAGE_BYTES - 1));
		it.data_byte  = 8'($urandom_range(0, 255));
		it.raw        = 1'($urandom_range(0, 1));
		it.miso       = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic spe_pkg::item_t tick_item(logic miso);
		spe_pkg::item_t it;
		it      = noise_item(spe_pkg::OP_TICK);
		it.miso = miso;
		return it;
	endfunction

	function automatic spe_pkg::item_t load_item(logic [5:0] idx, logic [7:0] data);
		spe_pkg::item_t it;
		it            = noise_item(spe_pkg::OP_LOAD);
		it.byte_index = idx;
		it.data_byte  = data;
		return it;
	endfunction

	function automatic spe_pkg::item_t start_item(logic [1:0] op, logic [8:0] page,
			logic raw);
		spe_pkg::item_t it;
		it      = noise_item(op);
		it.page = page;
		it.raw  = raw;
		return it;
	endfunction

	function automatic void fill_image(bit good);
		logic [7:0] sum;
		sum = 8'h00;
		for (int i = 1; i < spe_pkg::PAGE_BYTES; i++) begin
			eeprom_image[i] = 8'($urandom_range(0, 255));
			sum             = sum + eeprom_image[i];
		end
		eeprom_image[0] = good ? ~sum : 8'($urandom_range(0, 255));
		image_on        = 1'b1;
	endfunction

	// one transfer on the item channel, sent in bursts with random gaps
	task automatic send_item(input spe_pkg::item_t it);
		spe_pkg::result_t r;
		int               gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if ($urandom_range(0, 15) == 0)
				gap = $urandom_range(9, 20);
			if (gap != 0) begin
				if (offering)
					item_valid <= 1'b0;
				offering = 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		item       <= it;
		item_valid <= 1'b1;
		offering = 1'b1;
		@(posedge clk);
		while (item_stall !== 1'b0) @(posedge clk);
		burst_left--;
		r = spi_master_step(it);
		line_state_q.push_back(r);
	endtask

	task automatic run_ticks(input int n);
		repeat (n) send_item(tick_item(planned_miso()));
	endtask

	task automatic finish_transaction(input bit noisy);
		while (eng_phase != spe_pkg::PH_IDLE) begin
			if (noisy && $urandom_range(0, 29) == 0)
				send_item(noise_item(2'($urandom_range(spe_pkg::OP_LOAD, spe_pkg::OP_READ))));
			else
				send_item(tick_item(planned_miso()));
		end
	endtask

	task automatic settle();
		if (offering)
			item_valid <= 1'b0;
		offering   = 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (line_state_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [7:0] value);
		settle();
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		half_bit = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_idle_ops();
		repeat (3) send_item(tick_item(1'b1));
		send_item(tick_item(1'b0));
		send_item(load_item(6'd0, 8'hFF));
		send_item(load_item(6'd63, 8'h00));
		send_item(load_item(6'd1, 8'hFF));
		send_item(load_item(6'd63, 8'hFF));
		send_item(load_item(6'd32, 8'hA5));
		send_item(load_item(6'd1, 8'h5A));
		send_item(load_item(6'd0, 8'h3C));
	endtask

	task automatic test_busy_ignored();
		cfg_write(8'd1);
		fill_image(1'b1);
		send_item(start_item(spe_pkg::OP_READ, 9'h155, 1'b0));
		run_ticks(3);
		send_item(load_item(6'd5, 8'h77));
		send_item(start_item(spe_pkg::OP_READ, 9'h0C3, 1'b0));
		send_item(start_item(spe_pkg::OP_WRITE, 9'h13C, 1'b0));
		run_ticks(40);
		send_item(load_item(6'd0, 8'h00));
	endtask

	task automatic test_backpressure();
		long_hold = 400;
		run_ticks(200);
	endtask

	task automatic test_read_checksum();
		// the read under way runs out to its checksum flag
		finish_transaction(1'b1);
	endtask

	task automatic test_write_checksum();
		// zero divider runs like one
		cfg_write(8'd0);
		send_item(load_item(6'd17, 8'hC3));
		send_item(start_item(spe_pkg::OP_WRITE, 9'h1FF, 1'b0));
		// enable frame, then the data frame past the checksum byte
		run_ticks(90);
	endtask

	task automatic test_divider_extremes();
		// slowest divider past one half bit, then a short one mid count
		cfg_write(8'd255);
		run_ticks(300);
		cfg_write(8'd2);
		run_ticks(120);
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			err_count++;
			if (err_count <= PRINT_LIMIT)
				$display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	// compares every result transfer with the oldest prediction
	always @(posedge clk) begin : result_check
		spe_pkg::result_t want;
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			if (line_state_q.size() == 0) begin
				err_count++;
				if (err_count <= PRINT_LIMIT)
					$display("%0t unexpected result: expected none actual %h", $time, result);
			end else begin
				want = line_state_q.pop_front();
				check_field("cs_n", want.cs_n, result.cs_n);
				check_field("sck", want.sck, result.sck);
				check_field("mosi", want.mosi, result.mosi);
				check_field("wp", want.wp, result.wp);
				check_field("busy_res", want.busy_res, result.busy_res);
				check_field("rd_valid", want.rd_valid, result.rd_valid);
				check_field("rd_index", want.rd_index, result.rd_index);
				check_field("rd_byte", want.rd_byte, result.rd_byte);
				check_field("done_res", want.done_res, result.done_res);
				check_field("sum_match", want.sum_match, result.sum_match);
			end
		end
	end

	// result side stalls on its own pattern, with one long hold set by the backpressure test
	initial begin : receiver
		stall_mode_t mode;
		int          span;
		int          hold;
		mode = STALL_NONE;
		span = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold != 0) begin
				hold      = long_hold;
				long_hold = 0;
				result_stall <= 1'b1;
				repeat (hold - 1) @(posedge clk);
			end else begin
				if (span == 0) begin
					mode = stall_mode_t'($urandom_range(0, 3));
					span = $urandom_range(16, 256);
				end
				span--;
				case (mode)
					STALL_NONE: result_stall <= 1'b0;
					STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
					STALL_PERIODIC: result_stall <= (span % 5 == 0);
					default: result_stall <= ($urandom_range(0, 9) < 7);
				endcase
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid === 1'b1 && item_stall === 1'b0)
					|| (result_valid === 1'b1 && result_stall === 1'b0)
					|| (cfg_valid === 1'b1 && cfg_ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		arst_n     <= 1'b0;
		cfg_valid  <= 1'b0;
		cfg_data   <= 8'h00;
		item_valid <= 1'b0;
		item       <= '0;
		engine_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_ops();
		test_busy_ignored();
		test_backpressure();
		test_read_checksum();
		test_write_checksum();
		test_divider_extremes();
		settle();
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/spe_pkg.sv
rtl/core/spe_page_store.sv
rtl/core/spe_serial_engine.sv
rtl/core/spi_eeprom_page_engine_top.sv
rtl/core/spe_checker.sv
test/testbench.sv
